@@ rtl/partition_cost_evaluator_defines.svh @@
`ifndef PARTITION_COST_EVALUATOR_DEFINES_SVH
`define PARTITION_COST_EVALUATOR_DEFINES_SVH

// same-cycle implication, clocked on aclk, off during reset
`define PCE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, clocked on aclk, off during reset
`define PCE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/pce_pkg.sv @@
package pce_pkg;

    localparam int BLOCK_W     = 3;
    localparam int BLOCK_SLOTS = 8;
    localparam int FACTOR_W    = 16;
    localparam int WEIGHT_W    = 16;
    localparam int NPARTS_W    = 4;
    localparam int OP_W        = 17;
    localparam int PROD_W      = FACTOR_W + OP_W;
    localparam int SUM_W       = PROD_W + 1;
    localparam int COST_W      = 48;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [1:0] REQ_PIN    = 2'd0;
    localparam logic [1:0] REQ_VERTEX = 2'd1;
    localparam logic [1:0] REQ_FINISH = 2'd2;

    localparam logic [1:0] RES_EDGE  = 2'd0;
    localparam logic [1:0] RES_PATH  = 2'd1;
    localparam logic [1:0] RES_TOTAL = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] CFG_NUM_PARTS     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_EDGE_FACTOR_A = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_EDGE_FACTOR_B = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_PATH_FACTOR   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_SNAKING       = 3'd4;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [BLOCK_W-1:0]  part_id;
        logic                last_in_group;
        logic [WEIGHT_W-1:0] edge_weight_a;
        logic [WEIGHT_W-1:0] edge_weight_b;
    } req_t;

    typedef struct packed {
        logic [1:0]        result_kind;
        logic [COST_W-1:0] cost_amt;
        logic              invalid_block_seen;
    } res_t;

    typedef struct packed {
        logic [NPARTS_W-1:0] num_parts_in_use;
        logic [FACTOR_W-1:0] edge_factor_a;
        logic [FACTOR_W-1:0] edge_factor_b;
        logic [FACTOR_W-1:0] path_factor;
        logic [FACTOR_W-1:0] revisit_factor;
    } cfg_t;

    // work handed from front to back
    typedef struct packed {
        logic [1:0]      kind;
        logic [OP_W-1:0] op_a;
        logic [OP_W-1:0] op_b;
        logic            invalid;
    } task_t;

endpackage

@@ rtl/pce_front.sv @@
`include "partition_cost_evaluator_defines.svh"

module pce_front
    import pce_pkg::*;
#(
    parameter int NUM_PARTS    = 8,
    parameter int MAX_PATH_LEN = 256
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  cfg_t  cfg,
    input  logic  s_valid,
    output logic  s_ready,
    input  req_t  s_req,
    input  logic  q_full,
    output logic  q_push,
    output task_t q_task
);

    localparam int CNT_W = $clog2(MAX_PATH_LEN + 1);
    localparam int LIM_W = ($clog2(NUM_PARTS + 1) > NPARTS_W) ?
                           $clog2(NUM_PARTS + 1) : NPARTS_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PATH_LEN);

    logic [BLOCK_W-1:0] prev_reg, prev_next;
    logic               started_reg, started_next;
    logic               cut_reg, cut_next;
    logic [CNT_W-1:0]   run_reg, run_next;
    logic [CNT_W-1:0]   max_reg, max_next;
    logic [CNT_W-1:0]   brc_reg [BLOCK_SLOTS];
    logic [CNT_W-1:0]   brc_next [BLOCK_SLOTS];
    logic               inv_reg, inv_next;

    logic               xfer;
    logic [LIM_W-1:0]   limit;
    logic               bad;
    logic               inv_now;
    logic               new_run;
    logic [CNT_W-1:0]   blk_cnt;
    logic               grp_push;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v >= CNT_MAX) ? CNT_MAX : v + 1'b1;
    endfunction

    assign s_ready = !q_full;
    assign xfer    = s_valid && s_ready;

    assign limit   = (LIM_W'(cfg.num_parts_in_use) > LIM_W'(NUM_PARTS)) ?
                     LIM_W'(NUM_PARTS) : LIM_W'(cfg.num_parts_in_use);
    assign bad     = LIM_W'(s_req.part_id) >= limit;
    assign inv_now = inv_reg || bad;
    assign new_run = !started_reg || (s_req.part_id != prev_reg);
    assign blk_cnt = sat_inc(brc_reg[s_req.part_id]);

    assign grp_push = q_push && (q_task.kind != RES_TOTAL);

    always_comb begin
        prev_next    = prev_reg;
        started_next = started_reg;
        cut_next     = cut_reg;
        run_next     = run_reg;
        max_next     = max_reg;
        inv_next     = inv_reg;
        for (int i = 0; i < BLOCK_SLOTS; i++) begin
            brc_next[i] = brc_reg[i];
        end
        q_push = 1'b0;
        q_task = '0;

        if (xfer) begin
            unique case (s_req.req_type)
                REQ_FINISH: begin
                    q_push         = 1'b1;
                    q_task.kind    = RES_TOTAL;
                    q_task.invalid = inv_reg;
                    inv_next       = 1'b0;
                end
                REQ_PIN, REQ_VERTEX: begin
                    inv_next = inv_now;
                    if (s_req.req_type == REQ_PIN) begin
                        if (started_reg && (s_req.part_id != prev_reg)) begin
                            cut_next = 1'b1;
                        end
                    end else if (new_run) begin
                        run_next = sat_inc(run_reg);
                        brc_next[s_req.part_id] = blk_cnt;
                        if (blk_cnt > max_reg) begin
                            max_next = blk_cnt;
                        end
                    end
                    prev_next    = s_req.part_id;
                    started_next = 1'b1;

                    if (s_req.last_in_group) begin
                        q_push         = 1'b1;
                        q_task.invalid = inv_now;
                        if (s_req.req_type == REQ_PIN) begin
                            q_task.kind = RES_EDGE;
                            if (cut_next) begin
                                q_task.op_a = OP_W'(s_req.edge_weight_a);
                                q_task.op_b = OP_W'(s_req.edge_weight_b);
                            end
                        end else begin
                            q_task.kind = RES_PATH;
                            if (run_next > CNT_W'(1)) begin
                                q_task.op_a = OP_W'(run_next - 1'b1);
                                if (max_next != '0) begin
                                    q_task.op_b = OP_W'(max_next - 1'b1);
                                end
                            end
                        end
                        // group closed
                        prev_next    = '0;
                        started_next = 1'b0;
                        cut_next     = 1'b0;
                        run_next     = '0;
                        max_next     = '0;
                        for (int i = 0; i < BLOCK_SLOTS; i++) begin
                            brc_next[i] = '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg    <= '0;
            started_reg <= 1'b0;
            cut_reg     <= 1'b0;
            run_reg     <= '0;
            max_reg     <= '0;
            inv_reg     <= 1'b0;
            for (int i = 0; i < BLOCK_SLOTS; i++) begin
                brc_reg[i] <= '0;
            end
        end else begin
            prev_reg    <= prev_next;
            started_reg <= started_next;
            cut_reg     <= cut_next;
            run_reg     <= run_next;
            max_reg     <= max_next;
            inv_reg     <= inv_next;
            for (int i = 0; i < BLOCK_SLOTS; i++) begin
                brc_reg[i] <= brc_next[i];
            end
        end
    end

    `PCE_ASSERT_NEXT(a_group_end_clears, grp_push, !started_reg && (run_reg == '0) && !cut_reg)

endmodule

@@ rtl/pce_queue.sv @@
`include "partition_cost_evaluator_defines.svh"

module pce_queue
    import pce_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  task_t push_data,
    output logic  full,
    input  logic  pop,
    output logic  pop_valid,
    output task_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    task_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `PCE_ASSERT_SAME(a_no_underflow, pop, count_reg != '0)
    `PCE_ASSERT_SAME(a_no_overflow, push && !pop, count_reg != CNT_W'(DEPTH))

endmodule

@@ rtl/pce_back.sv @@
`include "partition_cost_evaluator_defines.svh"

module pce_back
    import pce_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  cfg_t  cfg,
    input  logic  q_valid,
    input  task_t q_task,
    output logic  q_pop,
    output logic  m_valid,
    input  logic  m_ready,
    output res_t  m_res
);

    logic              a_valid_reg;
    logic [1:0]        a_kind_reg;
    logic              a_inv_reg;
    logic [PROD_W-1:0] a_p0_reg, a_p1_reg;

    logic              m_valid_reg;
    res_t              m_res_reg;
    logic [COST_W-1:0] total_reg, total_next;

    logic [FACTOR_W-1:0] f0, f1;
    logic                out_free, a_free, b_load;
    logic [SUM_W-1:0]    group_cost;
    logic [COST_W:0]     total_sum;

    assign out_free = !m_valid_reg || m_ready;
    assign a_free   = !a_valid_reg || out_free;
    assign q_pop    = q_valid && a_free;
    assign b_load   = a_valid_reg && out_free;

    always_comb begin
        unique case (q_task.kind)
            RES_EDGE: begin
                f0 = cfg.edge_factor_a;
                f1 = cfg.edge_factor_b;
            end
            RES_PATH: begin
                f0 = cfg.path_factor;
                f1 = cfg.revisit_factor;
            end
            default: begin
                f0 = '0;
                f1 = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_free) begin
            a_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            a_kind_reg <= q_task.kind;
            a_inv_reg  <= q_task.invalid;
            a_p0_reg   <= PROD_W'(f0) * PROD_W'(q_task.op_a);
            a_p1_reg   <= PROD_W'(f1) * PROD_W'(q_task.op_b);
        end
    end

    assign group_cost = SUM_W'(a_p0_reg) + SUM_W'(a_p1_reg);
    assign total_sum  = {1'b0, total_reg} + (COST_W + 1)'(group_cost);

    always_comb begin
        total_next = total_reg;
        if (b_load) begin
            if (a_kind_reg == RES_TOTAL) begin
                total_next = '0;
            end else if (total_sum[COST_W]) begin
                total_next = '1;
            end else begin
                total_next = total_sum[COST_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            total_reg   <= '0;
        end else begin
            total_reg <= total_next;
            if (out_free) begin
                m_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (b_load) begin
            m_res_reg.result_kind        <= a_kind_reg;
            m_res_reg.invalid_block_seen <= a_inv_reg;
            m_res_reg.cost_amt           <= (a_kind_reg == RES_TOTAL) ?
                                            total_reg : COST_W'(group_cost);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

    `PCE_ASSERT_NEXT(a_finish_clears_total, b_load && (a_kind_reg == RES_TOTAL), total_reg == '0)

endmodule

@@ rtl/partition_cost_evaluator.sv @@
// a closing item's result is registered in the queue, then the multiply and output registers
// throughput: one item per cycle unless the queue is full; one multiply stage, one add stage
// a 4-entry queue between classifier and cost datapath absorbs m_ready stalls
// reset: aresetn low clears group state, total, flag and queue
// and loads register defaults (2 parts, factors 1.0, 0, 1.0, 1.0)
module partition_cost_evaluator
    import pce_pkg::*;
#(
    parameter int NUM_PARTS    = 8,
    parameter int MAX_PATH_LEN = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  req_t                  s_req,
    output logic                  m_valid,
    input  logic                  m_ready,
    output res_t                  m_res
);

    cfg_t  cfg_reg;
    logic  q_full, q_push, q_pop, q_valid;
    task_t q_in, q_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.num_parts_in_use <= NPARTS_W'(2);
            cfg_reg.edge_factor_a    <= FACTOR_W'(256);
            cfg_reg.edge_factor_b    <= '0;
            cfg_reg.path_factor      <= FACTOR_W'(256);
            cfg_reg.revisit_factor   <= FACTOR_W'(256);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_NUM_PARTS:     cfg_reg.num_parts_in_use <= cfg_wdata[NPARTS_W-1:0];
                CFG_EDGE_FACTOR_A: cfg_reg.edge_factor_a    <= cfg_wdata;
                CFG_EDGE_FACTOR_B: cfg_reg.edge_factor_b    <= cfg_wdata;
                CFG_PATH_FACTOR:   cfg_reg.path_factor      <= cfg_wdata;
                CFG_SNAKING:       cfg_reg.revisit_factor   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    pce_front #(
        .NUM_PARTS    (NUM_PARTS),
        .MAX_PATH_LEN (MAX_PATH_LEN)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_task  (q_in)
    );

    pce_queue #(
        .DEPTH (4)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_out)
    );

    pce_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_task  (q_out),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res)
    );

endmodule

@@ verif/partition_cost_evaluator_tb.sv @@
`timescale 1ns / 100ps

module partition_cost_evaluator_tb;
    import pce_pkg::*;

    localparam int NUM_PARTS    = 8;
    localparam int MAX_PATH_LEN = 256;
    localparam int QUIET_LIMIT  = 2000;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    req_t                  s_req     = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    res_t                  m_res;

    bit   pacing       = 1'b1;
    int   mismatches   = 0;
    int   quiet_cycles = 0;
    res_t expected_scores[$];

    // predictor state
    cfg_t                regs = '{4'd2, 16'd256, 16'd0, 16'd256, 16'd256};
    logic [BLOCK_W-1:0]  prev_block   = '0;
    bit                  group_open   = 1'b0;
    bit                  edge_cut     = 1'b0;
    logic [8:0]          run_total    = '0;
    logic [8:0]          block_runs [BLOCK_SLOTS] = '{default: '0};
    logic [8:0]          peak_runs    = '0;
    logic [COST_W-1:0]   total_cost   = '0;
    bit                  invalid_seen = 1'b0;

    partition_cost_evaluator #(
        .NUM_PARTS   (NUM_PARTS),
        .MAX_PATH_LEN(MAX_PATH_LEN)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_req    (s_req),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_res    (m_res)
    );

    always #4 aclk = ~aclk;

    function automatic logic [8:0] bump_runs(input logic [8:0] v);
        return (v >= 9'(MAX_PATH_LEN)) ? 9'(MAX_PATH_LEN) : v + 9'd1;
    endfunction

    function automatic bit score_request(input req_t r, output res_t res);
        logic [NPARTS_W-1:0] lim;
        logic [8:0]          cnt;
        logic [COST_W-1:0]   cost;
        logic [COST_W:0]     sum;
        res = '0;
        if (r.req_type == REQ_FINISH) begin
            res.result_kind        = RES_TOTAL;
            res.cost_amt           = total_cost;
            res.invalid_block_seen = invalid_seen;
            total_cost   = '0;
            invalid_seen = 1'b0;
            return 1'b1;
        end
        if (r.req_type != REQ_PIN && r.req_type != REQ_VERTEX)
            return 1'b0;
        lim = (regs.num_parts_in_use > NPARTS_W'(NUM_PARTS)) ?
              NPARTS_W'(NUM_PARTS) : regs.num_parts_in_use;
        if (NPARTS_W'(r.part_id) >= lim)
            invalid_seen = 1'b1;
        if (r.req_type == REQ_PIN) begin
            if (group_open && r.part_id != prev_block)
                edge_cut = 1'b1;
        end else if (!group_open || r.part_id != prev_block) begin
            run_total = bump_runs(run_total);
            cnt = bump_runs(block_runs[r.part_id]);
            block_runs[r.part_id] = cnt;
            if (cnt > peak_runs)
                peak_runs = cnt;
        end
        prev_block = r.part_id;
        group_open = 1'b1;
        if (!r.last_in_group)
            return 1'b0;

        if (r.req_type == REQ_PIN) begin
            cost = edge_cut ?
                   48'(r.edge_weight_a) * 48'(regs.edge_factor_a) +
                   48'(r.edge_weight_b) * 48'(regs.edge_factor_b) : '0;
        end else if (run_total <= 9'd1) begin
            cost = '0;
        end else begin
            cost = 48'(regs.path_factor) * 48'(run_total - 9'd1);
            if (peak_runs >= 9'd1)
                cost += 48'(regs.revisit_factor) * 48'(peak_runs - 9'd1);
        end
        sum = {1'b0, total_cost} + {1'b0, cost};
        total_cost = sum[COST_W] ? '1 : sum[COST_W-1:0];

        group_open = 1'b0;
        edge_cut   = 1'b0;
        run_total  = '0;
        peak_runs  = '0;
        prev_block = '0;
        foreach (block_runs[i])
            block_runs[i] = '0;

        res.result_kind        = (r.req_type == REQ_PIN) ? RES_EDGE : RES_PATH;
        res.cost_amt           = cost;
        res.invalid_block_seen = invalid_seen;
        return 1'b1;
    endfunction

    function automatic req_t make_req(input logic [1:0] t, input logic [BLOCK_W-1:0] b,
                                      input bit last, input logic [15:0] wa = '0,
                                      input logic [15:0] wb = '0);
        req_t r;
        r.req_type      = t;
        r.part_id       = b;
        r.last_in_group = last;
        r.edge_weight_a = wa;
        r.edge_weight_b = wb;
        return r;
    endfunction

    task automatic push_req(input req_t r);
        int   gap;
        res_t want;
        gap = pacing ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req   <= r;
        do @(posedge aclk); while (s_ready !== 1'b1);
        if (score_request(r, want))
            expected_scores.insert(expected_scores.size(), want);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (expected_scores.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic load_regs(input cfg_t c);
        logic [CFG_ADDR_W-1:0] idx  [5];
        logic [CFG_DATA_W-1:0] vals [5];
        settle();
        idx  = '{CFG_NUM_PARTS, CFG_EDGE_FACTOR_A, CFG_EDGE_FACTOR_B,
                 CFG_PATH_FACTOR, CFG_SNAKING};
        vals = '{{12'($urandom), c.num_parts_in_use}, c.edge_factor_a, c.edge_factor_b,
                 c.path_factor, c.revisit_factor};
        for (int i = 0; i < 5; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= idx[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        regs = c;
    endtask

    task automatic check_field(input string name, input logic [COST_W-1:0] want,
                               input logic [COST_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic test_default_regs();
        push_req(make_req(REQ_PIN, 3'd0, 1'b0));
        push_req(make_req(REQ_PIN, 3'd1, 1'b1, 16'hFFFF, 16'hFFFF));
        push_req(make_req(REQ_PIN, 3'd1, 1'b0));
        push_req(make_req(REQ_PIN, 3'd1, 1'b1, 16'h1234, 16'h5678));
        push_req(make_req(REQ_PIN, 3'd0, 1'b1, 16'hFFFF, 16'hFFFF));
        push_req(make_req(REQ_VERTEX, 3'd0, 1'b0));
        push_req(make_req(REQ_VERTEX, 3'd1, 1'b0));
        push_req(make_req(REQ_VERTEX, 3'd0, 1'b0));
        push_req(make_req(REQ_VERTEX, 3'd1, 1'b1));
        push_req(make_req(REQ_VERTEX, 3'd1, 1'b1));
        push_req(make_req(REQ_PIN, 3'd7, 1'b1, 16'h0000, 16'h0000));
        push_req(make_req(REQ_FINISH, 3'd7, 1'b1, 16'hFFFF, 16'hFFFF));
        push_req(make_req(REQ_FINISH, 3'd0, 1'b0));
    endtask

    task automatic test_mixed_groups();
        push_req(make_req(REQ_PIN, 3'd0, 1'b0));
        push_req(make_req(REQ_VERTEX, 3'd1, 1'b0));
        push_req(make_req(REQ_UNUSED, 3'd7, 1'b1, 16'hFFFF, 16'hFFFF));
        push_req(make_req(REQ_PIN, 3'd1, 1'b1, 16'hFFFF, 16'h0001));
        push_req(make_req(REQ_VERTEX, 3'd0, 1'b0));
        push_req(make_req(REQ_PIN, 3'd1, 1'b0));
        push_req(make_req(REQ_VERTEX, 3'd0, 1'b1));
        // finish inside an open edge
        push_req(make_req(REQ_PIN, 3'd0, 1'b0));
        push_req(make_req(REQ_FINISH, 3'd5, 1'b1, 16'hABCD, 16'h1234));
        push_req(make_req(REQ_PIN, 3'd1, 1'b1, 16'h0002, 16'h0003));
        push_req(make_req(REQ_FINISH, 3'd0, 1'b0));
    endtask

    task automatic test_part_limits();
        logic [NPARTS_W-1:0] limits [4];
        logic [FACTOR_W-1:0] f;
        limits = '{4'd0, 4'd1, 4'd8, 4'd15};
        foreach (limits[i]) begin
            f = (i % 2) ? 16'hFFFF : 16'h0000;
            load_regs('{limits[i], f, f, f, f});
            push_req(make_req(REQ_VERTEX, 3'd0, 1'b0));
            push_req(make_req(REQ_VERTEX, 3'd7, 1'b1));
            push_req(make_req(REQ_PIN, 3'd7, 1'b0));
            push_req(make_req(REQ_PIN, 3'd0, 1'b1, 16'hFFFF, 16'h0000));
            push_req(make_req(REQ_FINISH, 3'd0, 1'b0));
        end
    endtask

    task automatic test_long_path();
        load_regs('{4'd2, 16'hFFFF, 16'h0001, 16'hFFFF, 16'hFFFF});
        for (int i = 0; i < 262; i++)
            push_req(make_req(REQ_VERTEX, 3'(i % 2), i == 261));
        push_req(make_req(REQ_FINISH, 3'd0, 1'b0));
    endtask

    task automatic test_wide_costs();
        load_regs('{4'd8, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000});
        pacing = 1'b0;
        for (int i = 0; i < 20; i++) begin
            push_req(make_req(REQ_PIN, 3'd2, 1'b0));
            push_req(make_req(REQ_PIN, 3'd5, 1'b1, 16'hFFFF, 16'hFFFF));
        end
        push_req(make_req(REQ_FINISH, 3'd0, 1'b0));
        pacing = 1'b1;
    endtask

    task automatic test_random_traffic();
        cfg_t       c;
        req_t       r;
        int         sent;
        int         glen;
        int         spread;
        int         roll;
        bit         mixed;
        bit         open_end;
        logic [1:0] kind;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 3)
                0: c = '{4'($urandom_range(8, 15)), 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
                1: c = '{4'($urandom_range(0, 2)), 16'h0000, 16'h0000, 16'h0000, 16'h0000};
                default: c = '{4'($urandom_range(2, 8)), 16'($urandom), 16'($urandom),
                               16'($urandom), 16'($urandom)};
            endcase
            load_regs(c);
            pacing = ($urandom_range(0, 3) != 0);
            sent = 0;
            while (sent < 30) begin
                roll = $urandom_range(0, 99);
                if (roll < 6) begin
                    push_req(make_req(REQ_FINISH, 3'($urandom), 1'($urandom_range(0, 1)),
                                      16'($urandom), 16'($urandom)));
                    sent++;
                end else if (roll < 9) begin
                    push_req(make_req(REQ_UNUSED, 3'($urandom), 1'($urandom_range(0, 1)),
                                      16'($urandom), 16'($urandom)));
                end else begin
                    glen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20)
                                                       : $urandom_range(1, 5);
                    kind     = $urandom_range(0, 1) ? REQ_VERTEX : REQ_PIN;
                    mixed    = ($urandom_range(0, 9) == 0);
                    open_end = ($urandom_range(0, 19) == 0);
                    spread   = $urandom_range(1, 8);
                    for (int i = 0; i < glen; i++) begin
                        r.req_type = mixed ? ($urandom_range(0, 1) ? REQ_VERTEX : REQ_PIN)
                                           : kind;
                        r.part_id = ($urandom_range(0, 15) == 0) ?
                                    3'($urandom) : 3'($urandom_range(0, spread - 1));
                        r.last_in_group = (i == glen - 1) && !open_end;
                        r.edge_weight_a = 16'($urandom);
                        r.edge_weight_b = 16'($urandom);
                        push_req(r);
                    end
                    sent += glen;
                end
            end
            push_req(make_req(REQ_FINISH, 3'd0, 1'b0));
        end
        pacing = 1'b1;
    endtask

    // result side: random stall while pacing, then compare each transfer with the oldest prediction
    initial begin : result_monitor
        int   stall;
        res_t want;
        res_t got;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            stall = pacing ? $urandom_range(0, 9) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            got = m_res;
            if (expected_scores.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual kind %0d cost %0h flag %0b",
                         $time, got.result_kind, got.cost_amt, got.invalid_block_seen);
                mismatches++;
            end else begin
                want = expected_scores.pop_front();
                check_field("result_kind", 48'(want.result_kind), 48'(got.result_kind));
                check_field("cost_amt", want.cost_amt, got.cost_amt);
                check_field("invalid_block_seen", 48'(want.invalid_block_seen),
                            48'(got.invalid_block_seen));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_default_regs();
        test_mixed_groups();
        test_part_limits();
        test_long_path();
        test_wide_costs();
        test_random_traffic();
        settle();
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ partition_cost_evaluator.f @@
+incdir+rtl
rtl/pce_pkg.sv
rtl/pce_front.sv
rtl/pce_queue.sv
rtl/pce_back.sv
rtl/partition_cost_evaluator.sv
verif/partition_cost_evaluator_tb.sv
